[sv/srt_pkg.sv]
`default_nettype none

package srt_pkg;

  // table geometry, fixed by the field widths of the result item
  localparam int SLOT_COUNT = 4;
  localparam int MAX_PARTS  = 8;
  localparam int SLOT_IDX_W = 2;
  localparam int PIDX_W     = 3;
  localparam int MASK_W     = MAX_PARTS;

  // field widths
  localparam int TIME_W = 32;
  localparam int REF_W  = 16;
  localparam int SND_W  = 32;
  localparam int PART_W = 8;
  localparam int EXP_W  = 4;
  localparam int REP_W  = 8;
  localparam int RECV_W = 4;
  localparam int ACT_W  = 3;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd60000;

  // input item kinds
  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  // result actions
  typedef enum logic [ACT_W-1:0] {
    ACT_SINGLE    = 3'd0,
    ACT_WAITING   = 3'd1,
    ACT_COMPLETE  = 3'd2,
    ACT_DUPLICATE = 3'd3,
    ACT_DROPPED   = 3'd4,
    ACT_TIMEOUT   = 3'd5
  } action_t;

  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] now_time;
    logic [REF_W-1:0]  concat_ref;
    logic [SND_W-1:0]  sender_id;
    logic [PART_W-1:0] seg_num;
    logic [PART_W-1:0] total_parts;
  } in_item_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    slot_idx_t         slot_index;
    logic [PIDX_W-1:0] text_pos;
    logic [MASK_W-1:0] valid_mask;
    logic [EXP_W-1:0]  expected_count;
    logic [REP_W-1:0]  reported_count;
    logic              truncated;
    logic [REF_W-1:0]  group_ref;
    logic [SND_W-1:0]  group_sender;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      scan_en;
    slot_idx_t scan_idx;
    logic      commit;
  } srt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_result;
  } srt_status_t;

endpackage

`default_nettype wire

[sv/srt_ctrl.sv]
`default_nettype none

module srt_ctrl import srt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        out_stall,
  output logic             out_valid,
  input  wire srt_status_t status,
  output srt_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  state_t    state_r;
  slot_idx_t scan_idx_r;
  logic      out_valid_r;

  // commands decoded from the current state
  always_comb begin
    cmd.load     = (state_r == ST_IDLE) && in_valid;
    cmd.scan_en  = (state_r == ST_SCAN);
    cmd.scan_idx = scan_idx_r;
    cmd.commit   = (state_r == ST_APPLY) && (!out_valid_r || !out_stall);
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // sequencer: accept, walk the slots, apply and hand over the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit && status.has_result) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          scan_idx_r <= '0;
          if (in_valid) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan_idx_r <= scan_idx_r + slot_idx_t'(1);
          if (scan_idx_r == SLOT_IDX_W'(SLOT_COUNT - 1)) begin
            state_r <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (cmd.commit) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/srt_datapath.sv]
`default_nettype none

module srt_datapath import srt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [TIME_W-1:0] cfg_data,
  input  wire in_item_t          in_item,
  input  wire srt_cmd_t          cmd,
  output srt_status_t            status,
  output out_item_t              out_item
);

  // configuration and the item under work
  logic [TIME_W-1:0] timeout_r;
  in_item_t          item_r;
  out_item_t         out_item_r;

  // slot table
  logic              slot_used_r  [SLOT_COUNT];
  logic [REF_W-1:0]  slot_ref_r   [SLOT_COUNT];
  logic [SND_W-1:0]  slot_sender_r[SLOT_COUNT];
  logic [EXP_W-1:0]  slot_exp_r   [SLOT_COUNT];
  logic [REP_W-1:0]  slot_rep_r   [SLOT_COUNT];
  logic [RECV_W-1:0] slot_recv_r  [SLOT_COUNT];
  logic              slot_trunc_r [SLOT_COUNT];
  logic [MASK_W-1:0] slot_pv_r    [SLOT_COUNT];
  logic [TIME_W-1:0] slot_ft_r    [SLOT_COUNT];

  // scan results
  logic              hit_r;
  slot_idx_t         hit_idx_r;
  logic              free_found_r;
  slot_idx_t         free_idx_r;
  slot_idx_t         old_idx_r;
  logic [TIME_W-1:0] old_ft_r;
  logic [REF_W-1:0]  cand_ref_r;
  logic [SND_W-1:0]  cand_sender_r;
  logic [EXP_W-1:0]  cand_exp_r;
  logic [REP_W-1:0]  cand_rep_r;
  logic [RECV_W-1:0] cand_recv_r;
  logic              cand_trunc_r;
  logic [MASK_W-1:0] cand_pv_r;
  logic [TIME_W-1:0] cand_ft_r;

  // per-cycle view of the scanned slot
  logic              sc_used;
  logic [TIME_W-1:0] sc_ft;
  logic [TIME_W-1:0] sc_age;
  logic              sc_hit;

  always_comb begin
    sc_used = slot_used_r[cmd.scan_idx];
    sc_ft   = slot_ft_r[cmd.scan_idx];
    sc_age  = item_r.now_time - sc_ft;
    if (item_r.kind == KIND_TICK) begin
      sc_hit = sc_used && (sc_age >= timeout_r);
    end else begin
      sc_hit = sc_used && (slot_ref_r[cmd.scan_idx] == item_r.concat_ref)
               && (slot_sender_r[cmd.scan_idx] == item_r.sender_id);
    end
  end

  // apply step
  logic              pass;
  logic [EXP_W-1:0]  exp_new;
  logic              trunc_new;
  slot_idx_t         widx;
  logic [EXP_W-1:0]  b_exp;
  logic [REP_W-1:0]  b_rep;
  logic              b_trunc;
  logic [MASK_W-1:0] b_pv;
  logic [RECV_W-1:0] b_recv;
  logic [TIME_W-1:0] b_ft;
  logic [PART_W-1:0] pidx;
  logic [PIDX_W-1:0] bit_sel;
  logic [MASK_W-1:0] pv_upd;
  logic [RECV_W-1:0] recv_upd;
  logic [MASK_W-1:0] w_pv;
  logic [RECV_W-1:0] w_recv;
  logic              wr_slot;
  logic              clr_slot;
  logic              has_result;
  out_item_t         res;

  always_comb begin
    pass = (item_r.total_parts <= PART_W'(1)) || (item_r.seg_num == '0);
    trunc_new = item_r.total_parts > PART_W'(MAX_PARTS);
    if (item_r.total_parts == '0) begin
      exp_new = EXP_W'(1);
    end else if (trunc_new) begin
      exp_new = EXP_W'(MAX_PARTS);
    end else begin
      exp_new = item_r.total_parts[EXP_W-1:0];
    end

    // existing group or a fresh one in a free or evicted slot
    if (hit_r) begin
      widx    = hit_idx_r;
      b_exp   = cand_exp_r;
      b_rep   = (item_r.total_parts > cand_rep_r) ? item_r.total_parts : cand_rep_r;
      b_trunc = cand_trunc_r | trunc_new;
      b_pv    = cand_pv_r;
      b_recv  = cand_recv_r;
      b_ft    = cand_ft_r;
    end else begin
      widx    = free_found_r ? free_idx_r : old_idx_r;
      b_exp   = exp_new;
      b_rep   = item_r.total_parts;
      b_trunc = trunc_new;
      b_pv    = '0;
      b_recv  = '0;
      b_ft    = item_r.now_time;
    end

    pidx     = item_r.seg_num - PART_W'(1);
    bit_sel  = pidx[PIDX_W-1:0];
    pv_upd   = b_pv | (MASK_W'(1) << bit_sel);
    recv_upd = b_recv + RECV_W'(1);

    w_pv       = b_pv;
    w_recv     = b_recv;
    wr_slot    = 1'b0;
    clr_slot   = 1'b0;
    has_result = 1'b1;

    res.action         = ACT_DROPPED;
    res.slot_index     = widx;
    res.text_pos       = '0;
    res.valid_mask     = b_pv;
    res.expected_count = b_exp;
    res.reported_count = b_rep;
    res.truncated      = b_trunc;
    res.group_ref      = item_r.concat_ref;
    res.group_sender   = item_r.sender_id;

    priority if (item_r.kind == KIND_TICK) begin
      // timeout flush of the first due slot
      has_result         = hit_r;
      clr_slot           = hit_r;
      res.action         = ACT_TIMEOUT;
      res.slot_index     = hit_idx_r;
      res.valid_mask     = cand_pv_r;
      res.expected_count = cand_exp_r;
      res.reported_count = cand_rep_r;
      res.truncated      = cand_trunc_r;
      res.group_ref      = cand_ref_r;
      res.group_sender   = cand_sender_r;
    end else if (pass) begin
      res.action         = ACT_SINGLE;
      res.slot_index     = '0;
      res.valid_mask     = '0;
      res.expected_count = EXP_W'(1);
      res.reported_count = item_r.total_parts;
      res.truncated      = 1'b0;
    end else if (pidx >= PART_W'(b_exp)) begin
      wr_slot    = 1'b1;
      res.action = ACT_DROPPED;
    end else if (b_pv[bit_sel]) begin
      wr_slot    = 1'b1;
      res.action = ACT_DUPLICATE;
    end else begin
      res.text_pos   = bit_sel;
      res.valid_mask = pv_upd;
      if (recv_upd >= b_exp) begin
        clr_slot   = 1'b1;
        res.action = ACT_COMPLETE;
      end else begin
        wr_slot    = 1'b1;
        w_pv       = pv_upd;
        w_recv     = recv_upd;
        res.action = ACT_WAITING;
      end
    end
  end

  assign status.has_result = has_result;
  assign out_item          = out_item_r;

  // timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_data;
    end
  end

  // item capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.load) begin
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.scan_en) begin
      if (!hit_r && sc_hit) begin
        hit_r <= 1'b1;
      end
      if (!free_found_r && !sc_used) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.scan_en) begin
      if (!hit_r && sc_hit) begin
        hit_idx_r     <= cmd.scan_idx;
        cand_ref_r    <= slot_ref_r[cmd.scan_idx];
        cand_sender_r <= slot_sender_r[cmd.scan_idx];
        cand_exp_r    <= slot_exp_r[cmd.scan_idx];
        cand_rep_r    <= slot_rep_r[cmd.scan_idx];
        cand_recv_r   <= slot_recv_r[cmd.scan_idx];
        cand_trunc_r  <= slot_trunc_r[cmd.scan_idx];
        cand_pv_r     <= slot_pv_r[cmd.scan_idx];
        cand_ft_r     <= sc_ft;
      end
      if (!free_found_r && !sc_used) begin
        free_idx_r <= cmd.scan_idx;
      end
      // oldest first arrival, lowest index on a tie
      if ((cmd.scan_idx == '0) || (sc_ft < old_ft_r)) begin
        old_idx_r <= cmd.scan_idx;
        old_ft_r  <= sc_ft;
      end
    end
    if (cmd.commit && has_result) begin
      out_item_r <= res;
    end
  end

  // slot table write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_used_r[i] <= 1'b0;
      end
    end else if (cmd.commit) begin
      if (clr_slot) begin
        slot_used_r[widx] <= 1'b0;
      end else if (wr_slot) begin
        slot_used_r[widx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_slot) begin
      slot_ref_r[widx]    <= item_r.concat_ref;
      slot_sender_r[widx] <= item_r.sender_id;
      slot_exp_r[widx]    <= b_exp;
      slot_rep_r[widx]    <= b_rep;
      slot_recv_r[widx]   <= w_recv;
      slot_trunc_r[widx]  <= b_trunc;
      slot_pv_r[widx]     <= w_pv;
      slot_ft_r[widx]     <= b_ft;
    end
  end

endmodule

`default_nettype wire

[sv/sms_segment_reassembly_tracker_unit.sv]
`default_nettype none

// Multipart message segment tracker with a four-slot reassembly table.
// Input channel (in_valid / in_stall / in_item): one transfer is either a
// decoded segment or a timeout tick. Result channel (out_valid / out_stall /
// out_item): at most one result per input transfer; a tick with no slot due
// gives none. Configuration channel (cfg_valid / cfg_ready / cfg_data) writes
// the group timeout; cfg_ready is always high. Writes must go in while idle;
// the block does not enforce this. Each item takes an accept step, a scan
// step (one table slot per cycle, over every slot) and an apply step, with
// the result valid in the cycle after the apply step.
// The result sits in an output register, so the next item is accepted and
// scanned while a result is still stalled; its apply step waits until the
// output register is free.
// Reset (rst_n low, synchronous) empties every slot, drops any result held
// in the output register and sets the timeout to 60000 time units.
// The slot index and part index of a result address the external text store.

module sms_segment_reassembly_tracker_unit import srt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_item,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [TIME_W-1:0] cfg_data
);

  srt_cmd_t    cmd;
  srt_status_t status;

  assign cfg_ready = 1'b1;

  srt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  srt_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

  // an accepted item keeps the input side busy during the scan
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again before the slot scan");

  // a single pass result always reports one expected part and no slot data
  a_single_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.action == ACT_SINGLE) |->
      (out_item.expected_count == EXP_W'(1)) && (out_item.valid_mask == '0))
    else $error("single pass result with slot data");

  // timeout flushes carry no part position
  a_timeout_pidx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.action == ACT_TIMEOUT) |-> (out_item.text_pos == '0))
    else $error("timeout result with a part index");

endmodule

`default_nettype wire
